// ----- rtl/oahi_pkg.sv -----
// Shared types and constants for the open-addressing hash insert block.
`default_nettype none
package oahi_pkg;
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_CLEARED  = 2'd2;

	localparam logic [1:0] MODE_LINEAR    = 2'd0;
	localparam logic [1:0] MODE_QUADRATIC = 2'd1;
	localparam logic [1:0] MODE_DOUBLE    = 2'd2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_PROBE_MODE = 1'b1;

	localparam int SIZE_W  = 11;
	localparam int SLOT_W  = 10;
	localparam int PROBE_W = 11;
	localparam int KEY_W   = 32;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture key, start reductions
		logic red_step;  // one bit of the key reductions
		logic setup;     // form offsets and clear probe index
		logic addr;      // compute probe slot
		logic rd;        // issue map read
		logic mark;      // set the probed slot
		logic next;      // advance probe index
		logic clr_step;  // clear one map entry
		logic clr_start; // reset clear pointer
	} oahi_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic red_done;
		logic hit_free;
		logic last_probe;
		logic clr_done;
	} oahi_sts_t;
endpackage
`default_nettype wire

// ----- rtl/oahi_ctrl.sv -----
// Controller state machine for the open-addressing hash insert block.
`default_nettype none
module oahi_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_command,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire oahi_pkg::oahi_sts_t sts,
	output oahi_pkg::oahi_cmd_t   cmd,
	output logic [1:0]            res_kind
);
	import oahi_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RED   = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_ADDR  = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_TEST  = 4'd5;
	localparam logic [3:0] S_CLR   = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_INIT  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && !in_stall;
	assign res_kind  = kind_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				// post-reset sweep of the map, no result beat
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (in_command == CMD_CLEAR) begin
						cmd.clr_start = 1'b1;
						state_d = S_CLR;
					end else begin
						cmd.load = 1'b1;
						state_d = S_RED;
					end
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				if (sts.red_done) state_d = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_TEST;
			end
			S_TEST: begin
				if (sts.hit_free) begin
					cmd.mark = 1'b1;
					kind_d = ST_INSERTED;
					state_d = S_OUT;
				end else if (sts.last_probe) begin
					kind_d = ST_OVERFLOW;
					state_d = S_OUT;
				end else begin
					cmd.next = 1'b1;
					state_d = S_ADDR;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					kind_d = ST_CLEARED;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			kind_q  <= ST_INSERTED;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind_q)))
		else $error("stalled result changed");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.red_step, cmd.setup, cmd.addr, cmd.rd,
			cmd.mark, cmd.next, cmd.clr_step, cmd.clr_start}))
		else $error("more than one datapath command");
endmodule
`default_nettype wire

// ----- rtl/oahi_dp.sv -----
// Datapath: key reduction, probe address generation and occupancy map.
`default_nettype none
module oahi_dp #(
	parameter int SLOTS = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [oahi_pkg::KEY_W-1:0]  key,
	input  wire logic [oahi_pkg::SIZE_W-1:0] table_size,
	input  wire logic [1:0]                probe_mode,
	input  wire oahi_pkg::oahi_cmd_t       cmd,
	output oahi_pkg::oahi_sts_t            sts,
	output logic [oahi_pkg::SLOT_W-1:0]    slot_o,
	output logic [oahi_pkg::PROBE_W-1:0]   probes_o
);
	import oahi_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MW = $clog2(SLOTS + 1);
	localparam int KBW = $clog2(KEY_W + 1);
	localparam int W  = (MW > SIZE_W) ? MW : SIZE_W;

	// effective modulus, saturated into [2, SLOTS]
	logic [W-1:0] m_eff, ts_ext;
	assign ts_ext = W'(table_size);
	always_comb begin
		if (ts_ext < W'(2)) m_eff = W'(2);
		else if (ts_ext > W'(SLOTS)) m_eff = W'(SLOTS);
		else m_eff = ts_ext;
	end

	logic [KEY_W-1:0] key_q;
	logic [KBW-1:0]   bit_q;
	logic [W-1:0]     r_q, rm1_q, m_q, m1_q;
	logic [W:0]       r_sh, rm1_sh;
	logic [W-1:0]     base_q, off_q, d_q, i_q;
	logic [W-1:0]     slot_q;
	logic             rd_q;
	logic [MW-1:0]    clr_q;
	logic [1:0]       mode_q;
	logic             map_mem [SLOTS];

	// restoring reduction, one key bit per cycle for k mod m and k mod (m-1)
	assign r_sh   = {r_q, key_q[KEY_W-1]};
	assign rm1_sh = {rm1_q, key_q[KEY_W-1]};

	function automatic logic [W-1:0] modadd(input logic [W-1:0] a,
			input logic [W-1:0] b, input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	// small constant (below 7) mod m, m >= 2: three subtractions at most
	function automatic logic [W-1:0] small_mod(input logic [W-1:0] c,
			input logic [W-1:0] m);
		logic [W-1:0] v;
		v = c;
		for (int j = 0; j < 3; j++) begin
			if (v >= m) v = v - m;
		end
		return v;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key;
			r_q    <= '0;
			rm1_q  <= '0;
			m_q    <= m_eff;
			m1_q   <= m_eff - W'(1);
			mode_q <= probe_mode;
		end else if (cmd.red_step) begin
			key_q <= {key_q[KEY_W-2:0], 1'b0};
			r_q   <= (r_sh >= {1'b0, m_q}) ? W'(r_sh - {1'b0, m_q}) : r_sh[W-1:0];
			rm1_q <= (rm1_sh >= {1'b0, m1_q}) ? W'(rm1_sh - {1'b0, m1_q})
				: rm1_sh[W-1:0];
		end
		if (cmd.setup) begin
			// offset(i) = base + off; off advances by d, d by 6 (quadratic)
			base_q <= r_q;
			off_q  <= '0;
			i_q    <= '0;
			if (mode_q == MODE_QUADRATIC) begin
				d_q <= small_mod(W'(4), m_q);
			end else if (mode_q == MODE_DOUBLE) begin
				d_q <= modadd(rm1_q, W'(1), m_q);
			end else begin
				d_q <= W'(1);
			end
		end
		if (cmd.addr) slot_q <= modadd(base_q, off_q, m_q);
		if (cmd.next) begin
			i_q   <= i_q + W'(1);
			off_q <= modadd(off_q, d_q, m_q);
			if (mode_q == MODE_QUADRATIC) begin
				// delta(i) = 6i + 4 mod m, stepped by 6 mod m
				d_q <= modadd(d_q, small_mod(W'(6), m_q), m_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= map_mem[slot_q[AW-1:0]];
		if (cmd.mark) map_mem[slot_q[AW-1:0]] <= 1'b1;
		else if (cmd.clr_step) map_mem[clr_q[AW-1:0]] <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_start) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + MW'(1);
	end

	assign sts.red_done   = (bit_q == KBW'(KEY_W - 1));
	assign sts.hit_free   = !rd_q;
	assign sts.last_probe = (i_q == m_q - W'(1));
	assign sts.clr_done   = (clr_q == MW'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bit_q <= '0;
		else if (cmd.load) bit_q <= '0;
		else if (cmd.red_step) bit_q <= bit_q + KBW'(1);
	end

	assign slot_o   = SLOT_W'(slot_q);
	assign probes_o = PROBE_W'(i_q + W'(1));
endmodule
`default_nettype wire

// ----- rtl/open_addressing_hash_insert.sv -----
// Open-addressing hash insert: top level with config registers and result register.
// Insert: accept, key reduction and setup, then an address, read and test step per probe
//   until a free slot or the last probe gives the result beat; one item at a time.
// Clear: sweeps the occupancy memory, one entry a cycle, then gives the result.
// Reset clears control state and config (table_size = 1024, probe_mode = linear), then a
//   sweep frees every slot while the input stalls.
`default_nettype none
module open_addressing_hash_insert #(
	parameter int SLOTS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [oahi_pkg::SIZE_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        command,
	input  wire logic [oahi_pkg::KEY_W-1:0]   key,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       status,
	output logic [oahi_pkg::SLOT_W-1:0]       slot,
	output logic [oahi_pkg::PROBE_W-1:0]      probes
);
	import oahi_pkg::*;

	logic [SIZE_W-1:0] table_size_q;
	logic [1:0]        probe_mode_q;
	oahi_cmd_t         cmd;
	oahi_sts_t         sts;
	logic [1:0]        kind;
	logic [SLOT_W-1:0]  dp_slot;
	logic [PROBE_W-1:0] dp_probes;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(1024);
			probe_mode_q <= MODE_LINEAR;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TABLE_SIZE) table_size_q <= cfg_data;
			else probe_mode_q <= cfg_data[1:0];
		end
	end

	oahi_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_command(command), .in_stall,
		.out_valid, .out_stall, .sts, .cmd, .res_kind(kind)
	);

	oahi_dp #(.SLOTS(SLOTS)) u_dp (
		.clk, .arst_n, .key, .table_size(table_size_q), .probe_mode(probe_mode_q),
		.cmd, .sts, .slot_o(dp_slot), .probes_o(dp_probes)
	);

	// result beat fields; datapath holds still while the result waits
	assign status = kind;
	always_comb begin
		case (kind)
			ST_INSERTED: begin
				slot   = dp_slot;
				probes = dp_probes;
			end
			ST_OVERFLOW: begin
				slot   = '0;
				probes = dp_probes;
			end
			default: begin
				slot   = '0;
				probes = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- verif/tb_open_addressing_hash_insert.sv -----
// Self-checking testbench for the open-addressing hash insert block.
`default_nettype none
module tb_open_addressing_hash_insert;
	timeunit 1ns;
	timeprecision 1ps;
	import oahi_pkg::*;

	localparam int NSLOTS   = 1024;
	localparam int WD_LIMIT = 20000; // idle cycles; covers the worst insert plus a long hold-off
	localparam int N_RANDOM = 780;

	typedef struct packed {
		logic [1:0]         st;
		logic [SLOT_W-1:0]  sl;
		logic [PROBE_W-1:0] pr;
	} insert_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we = 1'b0;
	logic                cfg_index = CFG_TABLE_SIZE;
	logic [SIZE_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                command = CMD_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   slot;
	logic [PROBE_W-1:0]  probes;

	// predictor state: own copy of occupancy and registers
	bit                  occ_map [NSLOTS];
	logic [SIZE_W-1:0]   size_reg;
	logic [1:0]          mode_reg;
	insert_result_t      pending_results [$];

	int  errors = 0;
	int  n_sent = 0, n_checked = 0, n_overflow = 0, n_cleared = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  hold_off = 1'b0;
	int  stall_mode = 0;

	always #5 clk = ~clk;

	open_addressing_hash_insert #(.SLOTS(NSLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .slot(slot), .probes(probes)
	);

	// A clear empties the map; an insert probes until a free slot turns up; modulus saturates into [2, SLOTS].
	function automatic insert_result_t hash_insert_predict(logic c, logic [KEY_W-1:0] k);
		insert_result_t r;
		longint unsigned m, base, stride, s;
		r = '0;
		if (c == CMD_CLEAR) begin
			foreach (occ_map[j]) occ_map[j] = 1'b0;
			r.st = ST_CLEARED;
			return r;
		end
		m = size_reg;
		if (m < 2) m = 2;
		if (m > NSLOTS) m = NSLOTS;
		base = k % m;
		stride = 1 + (k % (m - 1));
		for (longint unsigned i = 0; i < m; i++) begin
			case (mode_reg)
				MODE_QUADRATIC: s = (base + i + 3 * i * i) % m;
				MODE_DOUBLE:    s = (base + i * stride) % m;
				default:        s = (base + i) % m; // mode 3 falls back to linear
			endcase
			if (!occ_map[s]) begin
				occ_map[s] = 1'b1;
				r.st = ST_INSERTED;
				r.sl = s[SLOT_W-1:0];
				r.pr = PROBE_W'(i + 1);
				return r;
			end
		end
		r.st = ST_OVERFLOW;
		r.pr = PROBE_W'(m);
		return r;
	endfunction

	// Register writes only while nothing is in flight.
	task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TABLE_SIZE) size_reg = val;
		else mode_reg = val[1:0];
	endtask

	task automatic set_table(logic [SIZE_W-1:0] sz, logic [1:0] md);
		write_reg(CFG_TABLE_SIZE, sz);
		write_reg(CFG_PROBE_MODE, md);
	endtask

	// One beat to the block, with bursty sender gaps afterwards.
	task automatic send_beat(logic c, logic [KEY_W-1:0] k);
		int gap;
		in_valid <= 1'b1;
		command <= c;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(hash_insert_predict(c, k));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	// receiver stall pattern: none, light or heavy, switching at random; always stalled during hold-off
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		if (hold_off) out_stall <= 1'b1;
		else case (stall_mode)
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= 1'b0;
		endcase
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		insert_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d slot %0d probes %0d",
					$time, status, slot, probes);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				n_checked++;
				if (exp_r.st == ST_OVERFLOW) n_overflow++;
				if (exp_r.st == ST_CLEARED) n_cleared++;
				if (status !== exp_r.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
					errors++;
				end
				if (slot !== exp_r.sl) begin
					$display("%0t: slot expected %0d actual %0d", $time, exp_r.sl, slot);
					errors++;
				end
				if (probes !== exp_r.pr) begin
					$display("%0t: probes expected %0d actual %0d", $time, exp_r.pr, probes);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// map comes out of reset empty; inserts first, then a clear
	task automatic test_reset_clear();
		arst_n <= 1'b0;
		foreach (occ_map[j]) occ_map[j] = 1'b0;
		size_reg = 11'd1024;
		mode_reg = MODE_LINEAR;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_beat(CMD_INSERT, 32'h0);
		send_beat(CMD_INSERT, 32'hFFFF_FFFF);
		send_beat(CMD_CLEAR, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_directed();
		// undersized table saturates to two slots, then overflows
		set_table(11'd0, MODE_LINEAR);
		send_beat(CMD_CLEAR, 32'h0);
		send_beat(CMD_INSERT, 32'h5);
		send_beat(CMD_INSERT, 32'h5);
		send_beat(CMD_INSERT, 32'h5);
		drain();
		set_table(11'd1, MODE_DOUBLE);
		send_beat(CMD_INSERT, 32'hFFFF_FFFF);
		// quadratic on four slots only reaches half of them
		set_table(11'd4, MODE_QUADRATIC);
		send_beat(CMD_CLEAR, 32'h0);
		send_beat(CMD_INSERT, 32'h1);
		send_beat(CMD_INSERT, 32'h1);
		send_beat(CMD_INSERT, 32'h1);
		// unused mode behaves as linear
		set_table(11'd7, 2'd3);
		send_beat(CMD_INSERT, 32'h8000_0000);
		send_beat(CMD_INSERT, 32'h8000_0000);
		// oversized table saturates to full size; shrink leaves upper slots occupied
		set_table(11'd2047, MODE_DOUBLE);
		send_beat(CMD_INSERT, 32'd1000);
		send_beat(CMD_INSERT, 32'hFFFF_FFFF);
		set_table(11'd16, MODE_LINEAR);
		send_beat(CMD_INSERT, 32'd1000);
		set_table(11'd1024, MODE_LINEAR);
		send_beat(CMD_INSERT, 32'd1000);
		send_beat(CMD_INSERT, 32'd1023);
		send_beat(CMD_CLEAR, 32'h0);
		drain();
	endtask

	// several settings, mostly small tables so overflows and collisions show up
	task automatic test_random();
		int done_items = 0, phase_len;
		logic [SIZE_W-1:0] sz;
		while (done_items < N_RANDOM) begin
			case ($urandom_range(0, 9))
				0:       sz = 11'd1024;
				1:       sz = SIZE_W'($urandom_range(1025, 2047));
				2:       sz = SIZE_W'($urandom_range(0, 2));
				default: sz = SIZE_W'($urandom_range(3, 64));
			endcase
			set_table(sz, 2'($urandom_range(0, 3)));
			phase_len = $urandom_range(20, 60);
			for (int n = 0; n < phase_len; n++) begin
				if ($urandom_range(0, 39) == 0) send_beat(CMD_CLEAR, $urandom);
				else send_beat(CMD_INSERT, $urandom);
			end
			done_items += phase_len;
			drain();
		end
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		set_table(11'd32, MODE_DOUBLE);
		fork
			begin
				hold_off = 1'b1;
				repeat (500) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		for (int n = 0; n < 12; n++) send_beat(CMD_INSERT, $urandom);
		drain();
	endtask

	initial begin
		test_reset_clear();
		test_directed();
		test_random();
		test_backpressure();
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d beats, checked %0d results (%0d overflows, %0d clears).",
			n_sent, n_checked, n_overflow, n_cleared);
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
